/* hdl/utf8s_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package utf8s_pkg;

   // window and queue sizes
   localparam int unsigned WIN_MAX  = 4;
   localparam int unsigned PEND_MAX = 3;
   localparam int unsigned QDEPTH   = 7;
   localparam int unsigned QROOM    = QDEPTH - WIN_MAX;

   // byte codes
   localparam logic [7:0] QMARK     = 8'h3F;
   localparam logic [7:0] ASCII_MAX = 8'h7F;
   localparam logic [7:0] CONT_LO   = 8'h80;
   localparam logic [7:0] CONT_HI   = 8'hBF;
   localparam logic [7:0] LEAD2_MIN = 8'hC0;
   localparam logic [7:0] LEAD2_LO  = 8'hC2;
   localparam logic [7:0] LEAD2_HI  = 8'hDF;
   localparam logic [7:0] LEAD3_E0  = 8'hE0;
   localparam logic [7:0] E0_B1_LO  = 8'hA0;
   localparam logic [7:0] LEAD3_E1  = 8'hE1;
   localparam logic [7:0] LEAD3_EC  = 8'hEC;
   localparam logic [7:0] LEAD3_ED  = 8'hED;
   localparam logic [7:0] ED_B1_HI  = 8'h9F;
   localparam logic [7:0] LEAD3_EE  = 8'hEE;
   localparam logic [7:0] LEAD3_EF  = 8'hEF;
   localparam logic [7:0] LEAD4_F0  = 8'hF0;
   localparam logic [7:0] F0_B1_LO  = 8'h90;
   localparam logic [7:0] LEAD4_F1  = 8'hF1;
   localparam logic [7:0] LEAD4_F3  = 8'hF3;
   localparam logic [7:0] LEAD4_F4  = 8'hF4;
   localparam logic [7:0] F4_B1_HI  = 8'h8F;

   // classification of one code point: ok, and length (1..4)
   typedef struct packed {
      logic       ok;
      logic [2:0] len;
   } cls_type;

   // one result item
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } ent_type;

   // results caused by one input item
   typedef struct packed {
      ent_type [WIN_MAX-1:0] ent;
      logic [2:0]            count;
   } res_type;

endpackage
`default_nettype wire

/* hdl/utf8s_classify.sv */
`timescale 1ns / 1ps
`default_nettype none
module utf8s_classify import utf8s_pkg::*; (
   input  logic [WIN_MAX-1:0][7:0] win,
   input  logic [2:0]              avail,
   output cls_type                 cls
);

   logic       h1, h2, h3;
   logic       vc1, vc2, vc3;
   logic [7:0] b0, b1;

   assign b0  = win[0];
   assign b1  = win[1];
   assign h1  = avail > 3'd1;
   assign h2  = avail > 3'd2;
   assign h3  = avail > 3'd3;
   assign vc1 = h1 && win[1] >= CONT_LO && win[1] <= CONT_HI;
   assign vc2 = h2 && win[2] >= CONT_LO && win[2] <= CONT_HI;
   assign vc3 = h3 && win[3] >= CONT_LO && win[3] <= CONT_HI;

   always_comb begin
      cls = '{ok: 1'b0, len: 3'd4};
      if (b0 <= ASCII_MAX) begin
         cls = '{ok: 1'b1, len: 3'd1};
      end else if (b0 >= LEAD2_LO && b0 <= LEAD2_HI && vc1) begin
         cls = '{ok: 1'b1, len: 3'd2};
      end else if ((b0 == LEAD3_E0 && vc1 && b1 >= E0_B1_LO && vc2) ||
                   (b0 >= LEAD3_E1 && b0 <= LEAD3_EC && vc1 && vc2) ||
                   (b0 == LEAD3_ED && vc1 && b1 <= ED_B1_HI && vc2) ||
                   (b0 >= LEAD3_EE && b0 <= LEAD3_EF && vc1 && vc2)) begin
         cls = '{ok: 1'b1, len: 3'd3};
      end else if ((b0 == LEAD4_F0 && vc1 && b1 >= F0_B1_LO && vc2 && vc3) ||
                   (b0 >= LEAD4_F1 && b0 <= LEAD4_F3 && vc1 && vc2 && vc3) ||
                   (b0 == LEAD4_F4 && vc1 && b1 <= F4_B1_HI && vc2 && vc3)) begin
         cls = '{ok: 1'b1, len: 3'd4};
      // malformed: apparent length from lead, cut at end of window
      end else if ((b0 >= CONT_LO && b0 <= CONT_HI) || !h1) begin
         cls = '{ok: 1'b0, len: 3'd1};
      end else if ((b0 >= LEAD2_MIN && b0 <= LEAD2_HI) || !h2) begin
         cls = '{ok: 1'b0, len: 3'd2};
      end else if ((b0 >= LEAD3_E0 && b0 <= LEAD3_EF) || !h3) begin
         cls = '{ok: 1'b0, len: 3'd3};
      end
   end

endmodule
`default_nettype wire

/* hdl/utf8s_step.sv */
`timescale 1ns / 1ps
`default_nettype none
module utf8s_step import utf8s_pkg::*; (
   input  logic [PEND_MAX-1:0][7:0] pend_bytes,
   input  logic [1:0]               pend_count,
   input  logic [7:0]               in_byte,
   input  logic                     in_last,
   output res_type                  res,
   output logic [PEND_MAX-1:0][7:0] next_bytes,
   output logic [1:0]               next_count
);

   logic [WIN_MAX-1:0][7:0] w;
   logic [2:0]              n;
   cls_type                 cls_at [WIN_MAX];

   // window: pending bytes, then the new one
   always_comb begin
      for (int i = 0; i < WIN_MAX; i++) begin
         if (i < pend_count) begin
            w[i] = pend_bytes[i];
         end else if (i == pend_count) begin
            w[i] = in_byte;
         end else begin
            w[i] = '0;
         end
      end
   end

   assign n = {1'b0, pend_count} + 3'd1;

   // classify every start position in parallel
   for (genvar p = 0; p < WIN_MAX; p++) begin : g_pos
      logic [WIN_MAX-1:0][7:0] sub;
      logic [2:0]              avail;
      for (genvar q = 0; q < WIN_MAX; q++) begin : g_sub
         if (p + q < WIN_MAX) begin : g_in
            assign sub[q] = w[p+q];
         end else begin : g_out
            assign sub[q] = '0;
         end
      end
      assign avail = (n > 3'(p)) ? n - 3'(p) : 3'd0;
      utf8s_classify u_cls (
         .win   (sub),
         .avail (avail),
         .cls   (cls_at[p])
      );
   end

   // walk the decisions: all of them at string end, the front one on a full window
   always_comb begin
      logic [2:0] pos;
      logic [2:0] k;
      logic [2:0] ndec;
      logic [2:0] src;
      cls_type    c;
      pos  = '0;
      k    = '0;
      src  = '0;
      c    = '{ok: 1'b0, len: 3'd1};
      ndec = in_last ? 3'd4 : ((n == 3'(WIN_MAX)) ? 3'd1 : 3'd0);
      for (int i = 0; i < WIN_MAX; i++) begin
         res.ent[i] = '{data: QMARK, last: 1'b0};
      end
      for (int j = 0; j < WIN_MAX; j++) begin
         if (3'(j) < ndec && pos < n) begin
            c = cls_at[pos[1:0]];
            if (c.ok) begin
               for (int i = 0; i < WIN_MAX; i++) begin
                  src = pos + 3'(i);
                  if (3'(i) < c.len && src < n && k < 3'(WIN_MAX)) begin
                     res.ent[k[1:0]].data = w[src[1:0]];
                     k = k + 3'd1;
                  end
               end
            end else if (k < 3'(WIN_MAX)) begin
               res.ent[k[1:0]].data = QMARK;
               k = k + 3'd1;
            end
            pos = pos + c.len;
         end
      end
      for (int i = 0; i < WIN_MAX; i++) begin
         res.ent[i].last = in_last && (3'(i) == k - 3'd1);
      end
      res.count = k;

      // what stays undecided
      for (int i = 0; i < PEND_MAX; i++) begin
         src = pos + 3'(i);
         next_bytes[i] = (!in_last && src < n) ? w[src[1:0]] : 8'h00;
      end
      next_count = in_last ? 2'd0 : 2'(n - pos);
   end

endmodule
`default_nettype wire

/* hdl/utf8s_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module utf8s_queue import utf8s_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  res_type push_res,
   input  logic    pop,
   output logic    room,
   output logic    not_empty,
   output ent_type head
);

   ent_type    q_ff  [QDEPTH];
   ent_type    q_in  [QDEPTH];
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] base;

   assign base      = cnt_ff - {2'b00, pop};
   assign room      = base <= 3'(QROOM);
   assign not_empty = cnt_ff != 3'd0;
   assign head      = q_ff[0];

   always_comb begin
      logic [2:0] at;
      at = '0;
      for (int i = 0; i < QDEPTH; i++) begin
         if (pop && i < QDEPTH - 1) begin
            q_in[i] = q_ff[i+1];
         end else begin
            q_in[i] = q_ff[i];
         end
      end
      for (int i = 0; i < WIN_MAX; i++) begin
         at = base + 3'(i);
         if (push && 3'(i) < push_res.count && at < 3'(QDEPTH)) begin
            q_in[at] = push_res.ent[i];
         end
      end
      cnt_in = base + (push ? push_res.count : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end

endmodule
`default_nettype wire

/* hdl/utf8_sanitizer.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel | ports                                     | carries
// req     | req_valid req_ready req_in_byte req_in_last | one string byte an item
// rsp     | rsp_valid rsp_ready rsp_out_byte rsp_out_last | one cleaned byte an item
//
// Decisions fall in the cycle a byte is taken; a taken byte yields 0..4 result
// bytes into a seven-entry queue, which sends one a cycle while rsp_ready is high.
// An item is taken in every cycle while the queue has room for four more, so
// the sustained rate is one byte a cycle, set by the single-byte result port.
// Reset (synchronous) empties the window and the queue.
// A stalled rsp side holds the queue head; req_ready drops while more than three
// bytes would stay queued after this cycle's send.
module utf8_sanitizer import utf8s_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   // undecided bytes, oldest first
   logic [PEND_MAX-1:0][7:0] pend_ff, pend_in;
   logic [1:0]               pcnt_ff, pcnt_in;

   res_type res;
   ent_type head;
   logic    take, give, room;

   assign take = req_valid && req_ready;
   assign give = rsp_valid && rsp_ready;

   // decode of window plus incoming byte
   utf8s_step u_step (
      .pend_bytes (pend_ff),
      .pend_count (pcnt_ff),
      .in_byte    (req_in_byte),
      .in_last    (req_in_last),
      .res        (res),
      .next_bytes (pend_in),
      .next_count (pcnt_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff <= '0;
         pend_ff <= '0;
      end else if (take) begin
         pcnt_ff <= pcnt_in;
         pend_ff <= pend_in;
      end
   end

   // result queue, drained one byte a cycle while rsp_ready is high
   utf8s_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_res  (res),
      .pop       (give),
      .room      (room),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign req_ready    = room;
   assign rsp_out_byte = head.data;
   assign rsp_out_last = head.last;

endmodule
`default_nettype wire

/* tb/sv/tb_utf8_sanitizer.sv */
`timescale 1ns / 1ps
module tb_utf8_sanitizer;
   import utf8s_pkg::*;

   // Stimulus sizing and limits
   localparam int unsigned RANDOM_ITEMS   = 300;
   localparam int unsigned HOLD_CYCLES    = 150;  // long rsp hold-off
   localparam int unsigned BURST_ITEMS    = 60;   // gapless items offered during the hold-off
   localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles with no handshake on either side
   localparam int unsigned SETTLE_CYCLES  = 20;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam logic [7:0]  LEAD_BAD_LO    = 8'hF5; // F5..FF never start a code point

   // ------------------------------------------------------------------
   // Scoreboard: shadows the decode window, holds the expected bytes
   // ------------------------------------------------------------------
   class utf8_scoreboard;
      logic [7:0]  undecided [PEND_MAX];
      int unsigned undecided_n;
      ent_type     cleaned_q [$];
      int unsigned failures;

      function new();
         undecided_n = 0;
         failures = 0;
         foreach (undecided[i]) undecided[i] = '0;
      endfunction

      function int unsigned outstanding();
         return cleaned_q.size();
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
      endfunction

      function bit is_cont(logic [7:0] x);
         return x >= CONT_LO && x <= CONT_HI;
      endfunction

      // Length of the code point at w[p] if well formed, else minus its apparent length
      function int front_length(logic [7:0] w [WIN_MAX], int unsigned p, int unsigned n);
         int unsigned avail;
         logic [7:0]  b0, b1, b2, b3;
         bit          h1, h2, h3, c1, c2, c3;
         avail = n - p;
         h1 = avail > 1;
         h2 = avail > 2;
         h3 = avail > 3;
         b0 = w[p];
         b1 = h1 ? w[p+1] : '0;
         b2 = h2 ? w[p+2] : '0;
         b3 = h3 ? w[p+3] : '0;
         c1 = h1 && is_cont(b1);
         c2 = h2 && is_cont(b2);
         c3 = h3 && is_cont(b3);
         if (b0 <= ASCII_MAX) return 1;
         if (b0 >= LEAD2_LO && b0 <= LEAD2_HI && c1) return 2;
         if ((b0 == LEAD3_E0 && c1 && b1 >= E0_B1_LO && c2) ||
             (b0 >= LEAD3_E1 && b0 <= LEAD3_EC && c1 && c2) ||
             (b0 == LEAD3_ED && c1 && b1 <= ED_B1_HI && c2) ||
             (b0 >= LEAD3_EE && b0 <= LEAD3_EF && c1 && c2)) return 3;
         if ((b0 == LEAD4_F0 && c1 && b1 >= F0_B1_LO && c2 && c3) ||
             (b0 >= LEAD4_F1 && b0 <= LEAD4_F3 && c1 && c2 && c3) ||
             (b0 == LEAD4_F4 && c1 && b1 <= F4_B1_HI && c2 && c3)) return 4;
         // malformed: apparent length from the lead, cut short by what is left
         if (is_cont(b0) || !h1) return -1;
         if ((b0 >= LEAD2_MIN && b0 <= LEAD2_HI) || !h2) return -2;
         if ((b0 >= LEAD3_E0 && b0 <= LEAD3_EF) || !h3) return -3;
         return -4;
      endfunction

      function int unsigned decide(logic [7:0] w [WIN_MAX], int unsigned p, int unsigned n);
         int      len;
         ent_type e;
         len = front_length(w, p, n);
         e.last = 1'b0;
         if (len > 0) begin
            for (int i = 0; i < len; i++) begin
               e.data = w[p+i];
               cleaned_q.push_back(e);
            end
            return len;
         end
         e.data = QMARK;
         cleaned_q.push_back(e);
         return -len;
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         logic [7:0]  w [WIN_MAX];
         int unsigned n, p;
         ent_type     e;
         foreach (w[i]) w[i] = '0;
         n = undecided_n;
         for (int i = 0; i < n; i++) w[i] = undecided[i];
         w[n] = b;
         n++;
         p = 0;
         if (last) begin
            while (p < n) p += decide(w, p, n);
            e = cleaned_q.pop_back();
            e.last = 1'b1;
            cleaned_q.push_back(e);
            undecided_n = 0;
         end else begin
            if (n == WIN_MAX) p = decide(w, 0, n);
            undecided_n = n - p;
            for (int i = 0; i < PEND_MAX; i++) undecided[i] = (p + i < n) ? w[p+i] : '0;
         end
      endfunction

      function void check_byte(logic [7:0] b, logic last);
         ent_type e;
         if (cleaned_q.size() == 0) begin
            flag($sformatf("unexpected result byte %h last %b", b, last));
            return;
         end
         e = cleaned_q.pop_front();
         if (b !== e.data) flag($sformatf("out_byte expected %h got %h", e.data, b));
         if (last !== e.last) flag($sformatf("out_last expected %b got %b", e.last, last));
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT and clocking
   // ------------------------------------------------------------------
   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       req_in_last;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   utf8_sanitizer dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   utf8_scoreboard sb = new();

   // shared stimulus controls
   bit          hold_req;     // asks the receiver for one long hold-off
   bit          no_idle;      // both sides run flat out
   int unsigned burst_end;    // sender offers gapless items until this count
   int unsigned items_sent;
   logic [7:0]  str_bytes [$]; // string being built

   // Mostly back to back, some short gaps, the odd long one
   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] cont_byte();
      return 8'($urandom_range(CONT_LO, CONT_HI));
   endfunction

   // One well-formed code point with random content, all Table 3-7 rows
   function automatic void add_well_formed();
      logic [7:0] lead;
      case ($urandom_range(0, 4))
         0, 1: str_bytes.push_back(8'($urandom_range(1, ASCII_MAX)));
         2: begin
            str_bytes.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
            str_bytes.push_back(cont_byte());
         end
         3: begin
            lead = 8'($urandom_range(LEAD3_E0, LEAD3_EF));
            str_bytes.push_back(lead);
            if (lead == LEAD3_E0) str_bytes.push_back(8'($urandom_range(E0_B1_LO, CONT_HI)));
            else if (lead == LEAD3_ED) str_bytes.push_back(8'($urandom_range(CONT_LO, ED_B1_HI)));
            else str_bytes.push_back(cont_byte());
            str_bytes.push_back(cont_byte());
         end
         default: begin
            lead = 8'($urandom_range(LEAD4_F0, LEAD4_F4));
            str_bytes.push_back(lead);
            if (lead == LEAD4_F0) str_bytes.push_back(8'($urandom_range(F0_B1_LO, CONT_HI)));
            else if (lead == LEAD4_F4) str_bytes.push_back(8'($urandom_range(CONT_LO, F4_B1_HI)));
            else str_bytes.push_back(cont_byte());
            str_bytes.push_back(cont_byte());
            str_bytes.push_back(cont_byte());
         end
      endcase
   endfunction

   // Noise, truncated or corrupted sequences, bad leads and stray continuations
   function automatic void add_broken();
      int unsigned mark, pick;
      logic [7:0]  lead;
      mark = str_bytes.size();
      case ($urandom_range(0, 3))
         0: str_bytes.push_back(8'($urandom_range(1, 255)));
         1: begin
            add_well_formed();
            if (str_bytes.size() - mark > 1) void'(str_bytes.pop_back());
         end
         2: begin
            add_well_formed();
            pick = $urandom_range(mark, str_bytes.size() - 1);
            str_bytes[pick] = 8'($urandom_range(1, 255));
         end
         default: begin
            case ($urandom_range(0, 2))
               0: lead = 8'($urandom_range(LEAD2_MIN, LEAD2_LO - 1));
               1: lead = 8'($urandom_range(LEAD_BAD_LO, 255));
               default: lead = cont_byte();
            endcase
            str_bytes.push_back(lead);
            repeat ($urandom_range(0, 3)) str_bytes.push_back(cont_byte());
         end
      endcase
   endfunction

   function automatic void make_string();
      str_bytes.delete();
      repeat ($urandom_range(1, 8)) begin
         if ($urandom_range(0, 99) < 80) add_well_formed();
         else add_broken();
      end
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Drive on the falling edge, take the handshake on the rising edge.
   // valid is only lowered when a gap is wanted, so it never toggles twice in a step.
   task automatic send_item(input logic [7:0] b, input logic last, input int unsigned gap);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(b, last);
      items_sent++;
   endtask

   task automatic send_string();
      int unsigned gap;
      foreach (str_bytes[i]) begin
         gap = (items_sent < burst_end || no_idle) ? 0 : idle_gap();
         send_item(str_bytes[i], i == str_bytes.size() - 1, gap);
      end
   endtask

   // Sender pauses until every expected item has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: random ready, one long hold-off on request
   // ------------------------------------------------------------------
   initial begin : receiver
      int unsigned run;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            run = idle_gap();
            if (run == 0) begin
               rsp_ready <= 1'b1;
               run = $urandom_range(1, 12);
            end else begin
               rsp_ready <= 1'b0;
            end
            repeat (run - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_byte(rsp_out_byte, rsp_out_last);
   end

   // Watchdog: no handshake on either side for too long means a hang
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : main
      int unsigned s, random_start;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'h20;
      req_in_last = 1'b0;
      hold_req    = 1'b0;
      no_idle     = 1'b0;
      burst_end   = 0;
      items_sent  = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed strings
      // single-byte string; ASCII top, two-byte extremes, lone C1 at the end
      str_bytes = '{8'h01};
      send_string();
      str_bytes = '{8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hC1};
      send_string();
      // malformed three-byte lead swallows the ASCII behind it
      str_bytes = '{8'hE1, 8'h41, 8'h42, 8'h43};
      send_string();
      // top code point, stray continuation, FF alone at the end
      str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h80, 8'hFF};
      send_string();
      // overlong four-byte form, then a surrogate lead cut short by the end
      str_bytes = '{8'hF0, 8'h8F, 8'h80, 8'h80, 8'hED, 8'hA0};
      send_string();

      // Random strings, mostly well formed
      random_start = items_sent;
      s = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (s == 4) begin
            // long rsp hold-off while the sender keeps offering: fills the queue
            hold_req  = 1'b1;
            burst_end = items_sent + BURST_ITEMS;
         end
         if (s == 16) no_idle = 1'b1;
         if (s == 24) no_idle = 1'b0;
         if (s % 10 == 9) wait_drained();
         make_string();
         send_string();
         s++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
